// ===== design/icsc_pkg.sv =====
// ----------------------------------------------------------------------------
// icsc_pkg
// Shared codes, constants and helper functions for the image CRC checker.
// ----------------------------------------------------------------------------
`default_nettype none

package icsc_pkg;

    // Reflected CRC-32 polynomial and preset
    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    // Input selector codes (carried on s_tuser)
    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_IMAGE  = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    // Result kind codes (carried on m_tuser)
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_IMAGE  = 1'b1;

    // Header word positions with a special role
    localparam int unsigned HDR_IDX_PRESET   = 0;
    localparam int unsigned HDR_IDX_EXPECTED = 1;
    localparam int unsigned HDR_IDX_IMAGE    = 2;

    // Output beat layout
    localparam int unsigned M_TDATA_W = 40;

    // Swap the two nibbles of every byte
    function automatic logic [31:0] swap_nibbles(input logic [31:0] w);
        return ((w << 4) & 32'hf0f0f0f0) | ((w >> 4) & 32'h0f0f0f0f);
    endfunction

    // Response of 32 LSB-first shifts to a single set bit; evaluated on
    // constants only, to build the XOR matrix of one word step
    function automatic logic [31:0] crc_impulse(input int unsigned bit_pos);
        logic [31:0] c;
        c = 32'd1 << bit_pos;
        for (int i = 0; i < 32; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/icsc_crc_step.sv =====
// ----------------------------------------------------------------------------
// icsc_crc_step
// One reflected CRC-32 word step (32 shifts) as a flat XOR matrix.
// The caller xors the data word into the CRC before this step.
// ----------------------------------------------------------------------------
`default_nettype none

module icsc_crc_step (
    input  wire logic [31:0] din,
    output logic      [31:0] dout
);
    import icsc_pkg::*;

    logic [31:0] term [32];

    // Gate one matrix column per input bit
    for (genvar gi = 0; gi < 32; gi++) begin : g_col
        localparam logic [31:0] COL = crc_impulse(gi);
        assign term[gi] = din[gi] ? COL : 32'd0;
    end

    // Combine the columns
    always_comb begin
        dout = 32'd0;
        for (int j = 0; j < 32; j++) begin
            dout = dout ^ term[j];
        end
    end

endmodule

`default_nettype wire

// ===== design/image_crc_stream_checker_unit.sv =====
// ----------------------------------------------------------------------------
// image_crc_stream_checker_unit
// Streams a firmware image through a word-wise reflected CRC-32, checks the
// header page against its stored CRC and reports the final image check.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  s_      | in  | [31:0] data_word               | [1:0] func
//  m_      | out | [0] header_error,[32:1] check  | [0] result_kind
//
//  One beat per cycle while s_tready is high: every input beat is finished
//  in the cycle it is accepted, and its result (if any) sits in the output
//  register next cycle. The path is two chained CRC word steps (fold plus
//  header check). s_tready drops only while a result waits in the output
//  register and m_tready is low. Reset is synchronous on aresetn.
// ----------------------------------------------------------------------------
`default_nettype none

module image_crc_stream_checker_unit #(
    parameter int unsigned HEADER_WORDS = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [31:0]                         s_tdata,  // [31:0] data_word
    input  wire logic [1:0]                          s_tuser,  // [1:0] func
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [icsc_pkg::M_TDATA_W-1:0]           m_tdata,  // [0] header_error,
                                                               // [32:1] check_value
    output logic                                     m_tuser   // [0] result_kind
);
    import icsc_pkg::*;

    localparam int unsigned IDX_W = $clog2(HEADER_WORDS);

    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      expected_reg, expected_next;
    logic [31:0]      image_reg, image_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_kind_reg, m_kind_next;
    logic             m_err_reg, m_err_next;
    logic [31:0]      m_check_reg, m_check_next;

    logic             s_accept;
    logic             emit;
    logic [31:0]      word;
    logic [31:0]      fold_in, fold_out;
    logic [31:0]      chk_in, chk_out;
    logic             last_hdr;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign word     = swap_nibbles(s_tdata);
    assign last_hdr = (idx_reg == IDX_W'(HEADER_WORDS - 1));

    // Fold either the incoming word or the expected value into the CRC
    assign fold_in = crc_reg ^ ((s_tuser == FUNC_FINISH) ? expected_reg : word);

    icsc_crc_step u_fold (
        .din  (fold_in),
        .dout (fold_out)
    );

    // Header check: fold the expected header CRC into the updated CRC
    assign chk_in = fold_out ^ expected_reg;

    icsc_crc_step u_check (
        .din  (chk_in),
        .dout (chk_out)
    );

    // Next state and result
    always_comb begin
        crc_next      = crc_reg;
        expected_next = expected_reg;
        image_next    = image_reg;
        idx_next      = idx_reg;
        emit          = 1'b0;
        m_kind_next   = m_kind_reg;
        m_err_next    = m_err_reg;
        m_check_next  = m_check_reg;
        if (s_accept) begin
            case (s_tuser)
                FUNC_HEADER: begin
                    if (idx_reg == IDX_W'(HDR_IDX_PRESET)) begin
                        crc_next = CRC_ONES;
                    end else if (idx_reg == IDX_W'(HDR_IDX_EXPECTED)) begin
                        expected_next = word;
                    end else if (idx_reg == IDX_W'(HDR_IDX_IMAGE)) begin
                        image_next = word;
                    end else begin
                        crc_next = fold_out;
                    end
                    if (last_hdr) begin
                        emit         = 1'b1;
                        m_kind_next  = KIND_HEADER;
                        m_err_next   = (~chk_out != 32'd0);
                        m_check_next = 32'd0;
                        idx_next     = '0;
                        if (~chk_out == 32'd0) begin
                            expected_next = image_reg;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                FUNC_IMAGE: begin
                    crc_next = fold_out;
                end
                FUNC_FINISH: begin
                    crc_next     = fold_out;
                    emit         = 1'b1;
                    m_kind_next  = KIND_IMAGE;
                    m_err_next   = 1'b0;
                    m_check_next = ~fold_out;
                end
                default: begin
                    // unused selector: drop the beat
                end
            endcase
        end
    end

    // Output register valid: load on a result, release when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and CRC state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_ONES;
            expected_reg <= 32'd0;
            image_reg    <= 32'd0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            crc_reg      <= crc_next;
            expected_reg <= expected_next;
            image_reg    <= image_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_err_reg   <= m_err_next;
        m_check_reg <= m_check_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {(M_TDATA_W - 33)'(0), m_check_reg, m_err_reg};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the image CRC stream checker. Drives header pages, image words
// and finish beats, mostly as well-formed images whose header and image CRCs
// are solved on the fly. The rest are corrupted CRCs, beats mixed into the
// header, unused selectors and raw noise. A scoreboard predicts every result
// beat and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import icsc_pkg::*;

    localparam int unsigned HDR_WORDS      = 64;
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
    localparam int unsigned ITEM_TARGET    = 850;
    localparam int unsigned TIMEOUT_CYCLES = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // [31:0] data_word
    logic [1:0]            s_tuser;   // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [0] header_error, [32:1] check_value
    logic                  m_tuser;   // [0] result_kind

    logic                  no_idle;
    int unsigned           sent_count;

    typedef struct {
        logic        kind;
        logic        err;
        logic [31:0] check;
    } check_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: running CRC predictor plus the queue of pending checks
    // ------------------------------------------------------------------------
    class crc_check_board;
        logic [31:0]  crc_acc;
        logic [31:0]  expect_crc;
        logic [31:0]  image_crc;
        int unsigned  hdr_pos;
        check_beat_t  pending_checks[$];
        int unsigned  results_seen;
        int unsigned  fail_count;

        function new();
            crc_acc      = CRC_ONES;
            expect_crc   = 32'd0;
            image_crc    = 32'd0;
            hdr_pos      = 0;
            results_seen = 0;
            fail_count   = 0;
        endfunction

        static function logic [31:0] nib_swap(logic [31:0] w);
            logic [31:0] r;
            for (int b = 0; b < 4; b++) begin
                r[8*b +: 4]     = w[8*b + 4 +: 4];
                r[8*b + 4 +: 4] = w[8*b +: 4];
            end
            return r;
        endfunction

        // One word step: xor in, then 32 LSB-first shifts
        static function logic [31:0] fold(logic [31:0] c, logic [31:0] w);
            logic [31:0] r;
            r = c ^ w;
            for (int i = 0; i < 32; i++) begin
                r = {1'b0, r[31:1]} ^ (r[0] ? CRC_POLY : 32'd0);
            end
            return r;
        endfunction

        // Undo the 32 shifts; the polynomial's top bit recovers each dropped LSB
        static function logic [31:0] unshift(logic [31:0] y);
            logic [31:0] r;
            logic        lsb;
            r = y;
            for (int i = 0; i < 32; i++) begin
                lsb = r[31];
                if (lsb) begin
                    r = r ^ CRC_POLY;
                end
                r = {r[30:0], lsb};
            end
            return r;
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            fail_count++;
            $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
        endtask

        // Advance the prediction for one accepted input beat
        function void take_word(logic [1:0] func, logic [31:0] raw);
            logic [31:0] w;
            logic [31:0] chk;
            check_beat_t beat;
            w = nib_swap(raw);
            case (func)
                FUNC_HEADER: begin
                    if (hdr_pos == HDR_IDX_PRESET) begin
                        crc_acc = CRC_ONES;
                    end else if (hdr_pos == HDR_IDX_EXPECTED) begin
                        expect_crc = w;
                    end else if (hdr_pos == HDR_IDX_IMAGE) begin
                        image_crc = w;
                    end else begin
                        crc_acc = fold(crc_acc, w);
                    end
                    if (hdr_pos == HDR_WORDS - 1) begin
                        // check on a copy; the running CRC keeps its value
                        chk        = ~fold(crc_acc, expect_crc);
                        beat.kind  = KIND_HEADER;
                        beat.err   = (chk != 32'd0);
                        beat.check = 32'd0;
                        if (!beat.err) begin
                            expect_crc = image_crc;
                        end
                        pending_checks.push_back(beat);
                        hdr_pos = 0;
                    end else begin
                        hdr_pos++;
                    end
                end
                FUNC_IMAGE: begin
                    crc_acc = fold(crc_acc, w);
                end
                FUNC_FINISH: begin
                    crc_acc    = fold(crc_acc, expect_crc);
                    beat.kind  = KIND_IMAGE;
                    beat.err   = 1'b0;
                    beat.check = ~crc_acc;
                    pending_checks.push_back(beat);
                end
                default: begin
                    // unused selector: no state change, no result
                end
            endcase
        endfunction

        // Compare one output beat against the oldest pending check
        task compare_result(logic kind, logic [M_TDATA_W-1:0] data);
            check_beat_t want;
            results_seen++;
            if (pending_checks.size() == 0) begin
                flag_mismatch("result with nothing pending", data[32:1], 32'd0);
                return;
            end
            want = pending_checks.pop_front();
            if (kind != want.kind) begin
                flag_mismatch("result_kind", 32'(kind), 32'(want.kind));
            end
            if (data[0] != want.err) begin
                flag_mismatch("header_error", 32'(data[0]), 32'(want.err));
            end
            if (data[32:1] != want.check) begin
                flag_mismatch("check_value", data[32:1], want.check);
            end
            if ((data >> 33) != '0) begin
                flag_mismatch("tdata padding", 32'(data >> 33), 32'd0);
            end
        endtask
    endclass

    crc_check_board sb;

    image_crc_stream_checker_unit #(
        .HEADER_WORDS (HDR_WORDS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock: period 8
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Result side: random backpressure outside the quiet window
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 8);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.compare_result(m_tuser, m_tdata);
        end
    end

    // Hold one beat until it is accepted, with random gaps ahead of it
    task automatic send_beat(logic [1:0] func, logic [31:0] word);
        while (!no_idle && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= func;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.take_word(func, word);
        if (func != FUNC_UNUSED) begin
            sent_count++;
        end
    endtask

    // Occasionally slip an image, finish or unused beat in
    task automatic maybe_stray_beat(bit enable);
        if (enable && $urandom_range(0, 99) < 6) begin
            send_beat(2'($urandom_range(1, 3)), $urandom);
        end
    endtask

    // One image: header page with solved CRCs, image words, finish beat.
    // mode 0: intact, 1: bad header CRC, 2: bad image CRC, 3: stray beats
    task automatic send_image_frame(int unsigned mode);
        logic [31:0] hdr [HDR_WORDS];
        logic [31:0] img [$];
        logic [31:0] crc;
        logic [31:0] ones_pre;
        int unsigned n_img;
        ones_pre = crc_check_board::unshift(CRC_ONES);
        crc      = CRC_ONES;
        hdr[0]   = $urandom;
        for (int i = 3; i < HDR_WORDS; i++) begin
            hdr[i] = $urandom;
            crc    = crc_check_board::fold(crc, crc_check_board::nib_swap(hdr[i]));
        end
        hdr[1] = crc_check_board::nib_swap(crc ^ ones_pre);
        n_img  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        for (int k = 0; k < n_img; k++) begin
            img.push_back($urandom);
            crc = crc_check_board::fold(crc, crc_check_board::nib_swap(img[k]));
        end
        hdr[2] = crc_check_board::nib_swap(crc ^ ones_pre);
        if (mode == 1) begin
            hdr[1] ^= 32'd1 << $urandom_range(0, 31);
        end
        if (mode == 2) begin
            hdr[2] ^= 32'd1 << $urandom_range(0, 31);
        end
        for (int i = 0; i < HDR_WORDS; i++) begin
            send_beat(FUNC_HEADER, hdr[i]);
            maybe_stray_beat(mode == 3);
        end
        foreach (img[k]) begin
            send_beat(FUNC_IMAGE, img[k]);
            if (mode == 3 && $urandom_range(0, 9) == 0) begin
                send_beat(FUNC_UNUSED, $urandom);
            end
        end
        send_beat(FUNC_FINISH, $urandom);
    endtask

    // Raw noise: any selector, any word, extremes now and then
    task automatic send_noise_burst();
        logic [31:0] w;
        repeat ($urandom_range(10, 30)) begin
            case ($urandom_range(0, 5))
                0:       w = 32'h0000_0000;
                1:       w = 32'hFFFF_FFFF;
                default: w = $urandom;
            endcase
            send_beat(2'($urandom_range(0, 3)), w);
        end
    endtask

    // Stimulus and end of run
    initial begin
        s_tvalid   <= 1'b0;
        s_tdata    <= 32'd0;
        s_tuser    <= FUNC_HEADER;
        m_tready   <= 1'b0;
        aresetn    <= 1'b0;
        no_idle    <= 1'b0;
        sent_count = 0;
        sb         = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unused selector, image and finish from reset, extremes
        send_beat(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_beat(FUNC_UNUSED, 32'h0000_0000);
        send_beat(FUNC_FINISH, 32'h0000_0000);
        send_beat(FUNC_IMAGE, 32'h0000_0000);
        send_beat(FUNC_IMAGE, 32'hFFFF_FFFF);
        send_beat(FUNC_IMAGE, 32'h0F0F_0F0F);
        send_beat(FUNC_IMAGE, 32'hF0F0_F0F0);
        send_beat(FUNC_FINISH, 32'hFFFF_FFFF);
        // mid-header: image, finish and unused beats leave the index alone
        send_beat(FUNC_HEADER, 32'hFFFF_FFFF);
        send_beat(FUNC_HEADER, 32'h1234_5678);
        send_beat(FUNC_IMAGE, 32'hA5A5_5A5A);
        send_beat(FUNC_FINISH, 32'h0000_0000);
        send_beat(FUNC_UNUSED, 32'hDEAD_BEEF);
        send_beat(FUNC_HEADER, 32'h8765_4321);
        send_beat(FUNC_HEADER, 32'h0000_0000);

        // Random: mostly well-formed images, some broken ones and noise
        while (sent_count < ITEM_TARGET) begin
            no_idle <= (sent_count >= 300 && sent_count < 450);
            // realign to a header boundary so frames start at word 0
            while (sb.hdr_pos != 0) begin
                send_beat(FUNC_HEADER, $urandom);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_image_frame(0);
                6:                send_image_frame(1);
                7:                send_image_frame(2);
                8:                send_image_frame(3);
                default:          send_noise_burst();
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain, then let the output register settle
        for (int n = 0; n < 2000 && sb.pending_checks.size() != 0; n++) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (sb.pending_checks.size() != 0) begin
            sb.flag_mismatch("results never arrived", sb.pending_checks.size(), 32'd0);
        end
        if (sb.fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 8);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
